[rtl/two_level_page_table_manager_macros.svh]
// Assertion macros for the two-level page table manager.
// No dependencies; included by the RTL files that carry assertions.
`ifndef TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH
`define TWO_LEVEL_PAGE_TABLE_MANAGER_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define TLPTM_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("page table manager assertion failed");

// Implication into the next cycle, disabled during reset.
`define TLPTM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("page table manager assertion failed");

`endif

[rtl/tlptm_pkg.sv]
// Types and fixed constants of the two-level page table manager.
// No dependencies; used by two_level_page_table_manager and the testbench.
package tlptm_pkg;

    // Command codes on the cmd field.
    typedef enum logic [1:0] {
        CMD_MAP   = 2'd0,
        CMD_UNMAP = 2'd1,
        CMD_XLATE = 2'd2
    } cmd_e_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIR,
        ST_ENT
    } state_t;

    localparam int DIR_SLOTS   = 1024;
    localparam int DIR_IDX_W   = 10;
    localparam int ENT_IDX_W   = 10;
    localparam int OFFSET_W    = 12;
    localparam int ADDR_W      = 32;
    localparam int CFG_W       = 5;
    localparam int COUNT_OUT_W = 15;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

endpackage

[rtl/two_level_page_table_manager.sv]
// Two-level page table manager: directory and entry memories with the command sequencer.
// Depends on tlptm_pkg and two_level_page_table_manager_macros.svh.
//
// After reset the block sweeps both memories, one entry per cycle, over all TABLE_SLOTS*1024 entries
// (16384 by default); in_stall stays high during that sweep, configuration writes are taken.
// Each command then does the directory read, the dependent entry read and the entry
// write-back with the result, in that order.
// The result sits in an output register, so the next command is accepted while it waits;
// a stalled result holds the command in its write-back state until the transfer completes.
`include "two_level_page_table_manager_macros.svh"

module two_level_page_table_manager #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write channel.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tlptm_pkg::CFG_W-1:0]         cfg_data,
    // Command channel.
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          cmd,
    input  logic [tlptm_pkg::ADDR_W-1:0]        virt_addr,
    input  logic [tlptm_pkg::ADDR_W-1:0]        phys_addr,
    input  logic [tlptm_pkg::OFFSET_W-1:0]      entry_flags,
    // Result channel.
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                status,
    output logic                                is_present,
    output logic [tlptm_pkg::ADDR_W-1:0]        translated_addr,
    output logic [tlptm_pkg::COUNT_OUT_W-1:0]   mapped_count
);

    localparam int TAB_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int ENT_DEPTH = TABLE_SLOTS * tlptm_pkg::DIR_SLOTS;
    localparam int ENT_AW    = TAB_W + tlptm_pkg::ENT_IDX_W;
    localparam int CNT_W     = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W     = (CNT_W > tlptm_pkg::CFG_W) ? CNT_W : tlptm_pkg::CFG_W;
    localparam int PC_W      = $clog2(ENT_DEPTH + 1);
    localparam int DIR_W     = TAB_W + 1;
    localparam int AW        = tlptm_pkg::ADDR_W;
    localparam int OW        = tlptm_pkg::OFFSET_W;

    // Control registers.
    tlptm_pkg::state_t              state_reg, state_next;
    logic [ENT_AW-1:0]              clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]               tables_used_reg, tables_used_next;
    logic [PC_W-1:0]                page_count_reg, page_count_next;
    logic [tlptm_pkg::CFG_W-1:0]    cfg_reg;
    logic                           out_valid_reg, out_valid_next;

    // Command and result payload registers.
    logic [1:0]                     cmd_reg, cmd_next;
    logic [AW-1:0]                  virt_reg, virt_next;
    logic [AW-1:0]                  phys_reg, phys_next;
    logic [OW-1:0]                  flags_reg, flags_next;
    logic [TAB_W-1:0]               tab_reg, tab_next;
    logic                           found_reg, found_next;
    logic                           status_reg, status_next;
    logic                           present_reg, present_next;
    logic [AW-1:0]                  xaddr_reg, xaddr_next;
    logic [tlptm_pkg::COUNT_OUT_W-1:0] count_reg, count_next;

    // Memory ports.
    logic [DIR_W-1:0]               dir_mem [tlptm_pkg::DIR_SLOTS];
    logic                           dir_we, dir_re;
    logic [tlptm_pkg::DIR_IDX_W-1:0] dir_waddr, dir_raddr;
    logic [DIR_W-1:0]               dir_wdata, dir_rdata_reg;

    logic [AW-1:0]                  ent_mem [ENT_DEPTH];
    logic                           ent_we, ent_re;
    logic [ENT_AW-1:0]              ent_waddr, ent_raddr;
    logic [AW-1:0]                  ent_wdata, ent_rdata_reg;

    logic                           pool_full;
    logic                           page_present;
    logic                           out_load;

    // Directory memory: slot holds a valid bit over the table number.
    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_waddr] <= dir_wdata;
        end
        if (dir_re)
        begin
            dir_rdata_reg <= dir_mem[dir_raddr];
        end
    end

    // Entry memory: frame, flags and present bit of every page.
    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[ent_waddr] <= ent_wdata;
        end
        if (ent_re)
        begin
            ent_rdata_reg <= ent_mem[ent_raddr];
        end
    end

    // The pool is empty once the smaller of the register and TABLE_SLOTS is reached.
    assign pool_full = (tables_used_reg >= CNT_W'(TABLE_SLOTS)) ||
                       (CMP_W'(tables_used_reg) >= CMP_W'(cfg_reg));

    assign page_present = found_reg && ent_rdata_reg[0];
    assign out_load     = (state_reg == tlptm_pkg::ST_ENT) && (!out_valid_reg || !out_stall);

    // Sequencer: next state, memory accesses and result.
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        tables_used_next = tables_used_reg;
        page_count_next  = page_count_reg;
        cmd_next         = cmd_reg;
        virt_next        = virt_reg;
        phys_next        = phys_reg;
        flags_next       = flags_reg;
        tab_next         = tab_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        present_next     = present_reg;
        xaddr_next       = xaddr_reg;
        count_next       = count_reg;
        dir_we           = 1'b0;
        dir_re           = 1'b0;
        dir_waddr        = virt_reg[AW-1 -: tlptm_pkg::DIR_IDX_W];
        dir_raddr        = virt_addr[AW-1 -: tlptm_pkg::DIR_IDX_W];
        dir_wdata        = '0;
        ent_we           = 1'b0;
        ent_re           = 1'b0;
        ent_waddr        = {tab_reg, virt_reg[OW +: tlptm_pkg::ENT_IDX_W]};
        ent_raddr        = '0;
        ent_wdata        = '0;

        unique case (state_reg)
            tlptm_pkg::ST_CLEAR:
            begin
                // Sweep both memories to the empty state.
                dir_we       = 1'b1;
                dir_waddr    = clr_cnt_reg[tlptm_pkg::DIR_IDX_W-1:0];
                ent_we       = 1'b1;
                ent_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ENT_AW'(ENT_DEPTH - 1))
                begin
                    state_next = tlptm_pkg::ST_IDLE;
                end
            end
            tlptm_pkg::ST_IDLE:
            begin
                // Take the command and read its directory slot.
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    virt_next  = virt_addr;
                    phys_next  = phys_addr;
                    flags_next = entry_flags;
                    dir_re     = 1'b1;
                    state_next = tlptm_pkg::ST_DIR;
                end
            end
            tlptm_pkg::ST_DIR:
            begin
                // Resolve the table, allocating one for a map to an empty slot while the pool has room.
                if (dir_rdata_reg[TAB_W])
                begin
                    tab_next   = dir_rdata_reg[TAB_W-1:0];
                    found_next = 1'b1;
                end
                else if ((cmd_reg == tlptm_pkg::CMD_MAP) && !pool_full)
                begin
                    tab_next         = tables_used_reg[TAB_W-1:0];
                    found_next       = 1'b1;
                    dir_we           = 1'b1;
                    dir_wdata        = {1'b1, tables_used_reg[TAB_W-1:0]};
                    tables_used_next = tables_used_reg + 1'b1;
                end
                else
                begin
                    tab_next   = '0;
                    found_next = 1'b0;
                end
                ent_re     = 1'b1;
                ent_raddr  = {tab_next, virt_reg[OW +: tlptm_pkg::ENT_IDX_W]};
                state_next = tlptm_pkg::ST_ENT;
            end
            tlptm_pkg::ST_ENT:
            begin
                // Write the entry back and load the result once the output is free.
                if (out_load)
                begin
                    status_next  = 1'b0;
                    present_next = 1'b0;
                    xaddr_next   = '0;
                    case (cmd_reg)
                        tlptm_pkg::CMD_MAP:
                        begin
                            if (!found_reg)
                            begin
                                status_next = 1'b1;
                            end
                            else
                            begin
                                ent_we    = 1'b1;
                                ent_wdata = {phys_reg[AW-1:OW], flags_reg[OW-1:1], 1'b1};
                                if (!ent_rdata_reg[0])
                                begin
                                    page_count_next = page_count_reg + 1'b1;
                                end
                            end
                        end
                        tlptm_pkg::CMD_UNMAP:
                        begin
                            if (page_present)
                            begin
                                ent_we    = 1'b1;
                                ent_wdata = '0;
                                if (page_count_reg != '0)
                                begin
                                    page_count_next = page_count_reg - 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                            if (page_present)
                            begin
                                present_next = 1'b1;
                                xaddr_next   = {ent_rdata_reg[AW-1:OW], virt_reg[OW-1:0]};
                            end
                        end
                    endcase
                    count_next = tlptm_pkg::COUNT_OUT_W'(page_count_next);
                    state_next = tlptm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tlptm_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid follows loads and completed transfers.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tlptm_pkg::ST_CLEAR;
            clr_cnt_reg     <= '0;
            tables_used_reg <= '0;
            page_count_reg  <= '0;
            cfg_reg         <= tlptm_pkg::CFG_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            tables_used_reg <= tables_used_next;
            page_count_reg  <= page_count_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        virt_reg    <= virt_next;
        phys_reg    <= phys_next;
        flags_reg   <= flags_next;
        tab_reg     <= tab_next;
        found_reg   <= found_next;
        status_reg  <= status_next;
        present_reg <= present_next;
        xaddr_reg   <= xaddr_next;
        count_reg   <= count_next;
    end

    assign cfg_ready       = 1'b1;
    assign in_stall        = (state_reg != tlptm_pkg::ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign is_present      = present_reg;
    assign translated_addr = xaddr_reg;
    assign mapped_count    = count_reg;

    // Checks on the sequencer and its counters.
    `TLPTM_ASSERT_IMPL(a_pool_bound, clk, rst_n, 1'b1, tables_used_reg <= CNT_W'(TABLE_SLOTS))
    `TLPTM_ASSERT_NEXT(a_dir_to_ent, clk, rst_n, state_reg == tlptm_pkg::ST_DIR,
        state_reg == tlptm_pkg::ST_ENT)
    `TLPTM_ASSERT_IMPL(a_count_in_ent, clk, rst_n, !$stable(page_count_reg),
        $past(state_reg) == tlptm_pkg::ST_ENT)
    `TLPTM_ASSERT_IMPL(a_alloc_in_dir, clk, rst_n, !$stable(tables_used_reg),
        $past(state_reg) == tlptm_pkg::ST_DIR && $past(cmd_reg) == tlptm_pkg::CMD_MAP)

endmodule

[tb/testbench.sv]
// Self-checking testbench for the two-level page table manager.
// Depends on tlptm_pkg and two_level_page_table_manager; holds its own page table predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_SLOTS = 16;
    localparam int TABLE_ENTRIES = 1024;
    localparam int DIR_COUNT = 1024;
    localparam logic [1:0] CMD_UNDEFINED = 2'd3;
    localparam int MAX_SHOWN = 10;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_GAP = 8;
    localparam int PHASES = 5;

    // One result of a command, field by field.
    typedef struct packed {
        logic        status;
        logic        is_present;
        logic [31:0] translated_addr;
        logic [14:0] mapped_count;
    } walk_result_t;

    // One directed command, with a fixed expectation where it is obvious.
    typedef struct packed {
        logic [1:0]   op;
        logic [31:0]  va;
        logic [31:0]  pa;
        logic [11:0]  flags;
        logic         fixed;
        walk_result_t want;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 21;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = '0;
    logic [31:0] virt_addr = '0;
    logic [31:0] phys_addr = '0;
    logic [11:0] entry_flags = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        status;
    logic        is_present;
    logic [31:0] translated_addr;
    logic [14:0] mapped_count;

    // Predictor state: directory slot holds table number plus one, zero when empty.
    int unsigned  dir_slot_tab [DIR_COUNT];
    logic [31:0]  page_entries [TABLE_SLOTS*TABLE_ENTRIES];
    int unsigned  tables_taken;
    int unsigned  present_pages;
    int unsigned  pool_limit;

    walk_result_t expected_walks [$];
    int           error_count = 0;
    int           shown_count = 0;
    int           item_no = 0;
    bit           steady_flow = 1'b0;
    bit           hold_off_req = 1'b0;
    logic [9:0]   hot_slots [24];
    logic [9:0]   hot_entries [8];

    // Limits for the random phases: first one below the tables already taken.
    int unsigned phase_limit [PHASES] = '{0, 5, 16, 31, 1};
    int          phase_items [PHASES] = '{80, 120, 150, 150, 100};

    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{tlptm_pkg::CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 15'd0}},
        '{tlptm_pkg::CMD_MAP,   32'h0000_0000, 32'hFFFF_FFFF, 12'hFFF, 1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 15'd1}},
        '{tlptm_pkg::CMD_XLATE, 32'h0000_0FFF, 32'h0000_0000, 12'h000, 1'b1,
          '{1'b0, 1'b1, 32'hFFFF_FFFF, 15'd1}},
        '{tlptm_pkg::CMD_MAP,   32'hFFFF_F000, 32'h0000_0000, 12'h000, 1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 15'd2}},
        '{tlptm_pkg::CMD_XLATE, 32'hFFFF_FFFF, 32'h0000_0000, 12'h000, 1'b1,
          '{1'b0, 1'b1, 32'h0000_0FFF, 15'd2}},
        // Pool of two tables is used up: a third slot is refused.
        '{tlptm_pkg::CMD_MAP,   32'h0040_0000, 32'h0000_1000, 12'h000, 1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 15'd2}},
        '{tlptm_pkg::CMD_XLATE, 32'h0040_0000, 32'h0000_0000, 12'h000, 1'b1,
          '{1'b0, 1'b0, 32'h0000_0000, 15'd2}},
        // Remap of a present page.
        '{tlptm_pkg::CMD_MAP,   32'h0000_0000, 32'h1234_5678, 12'h0AA, 1'b0, '0},
        '{CMD_UNDEFINED,        32'h0000_0ABC, 32'h0000_0000, 12'h000, 1'b0, '0},
        // Unmap of pages that are not present, in a live and in an empty slot.
        '{tlptm_pkg::CMD_UNMAP, 32'h0000_1000, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_UNMAP, 32'h0080_0000, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_UNMAP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_XLATE, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_UNMAP, 32'h0000_0000, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_MAP,   32'h003F_F000, 32'hABCD_E000, 12'h555, 1'b0, '0},
        '{tlptm_pkg::CMD_MAP,   32'hFFC0_0000, 32'h8000_0000, 12'hAAA, 1'b0, '0},
        '{tlptm_pkg::CMD_XLATE, 32'hFFC0_0123, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{CMD_UNDEFINED,        32'h0040_0000, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_MAP,   32'h0040_0000, 32'h0000_0000, 12'h000, 1'b1,
          '{1'b1, 1'b0, 32'h0000_0000, 15'd3}},
        '{tlptm_pkg::CMD_XLATE, 32'h003F_F800, 32'h0000_0000, 12'h000, 1'b0, '0},
        '{tlptm_pkg::CMD_UNMAP, 32'hFFFF_F000, 32'h0000_0000, 12'h000, 1'b0, '0}
    };

    two_level_page_table_manager #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .cmd(cmd),
        .virt_addr(virt_addr),
        .phys_addr(phys_addr),
        .entry_flags(entry_flags),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .is_present(is_present),
        .translated_addr(translated_addr),
        .mapped_count(mapped_count)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Finds the flat entry index of an address, taking a table from the pool if asked.
    // Returns -1 when the slot is empty and no table may be created.
    function automatic int find_entry(input logic [31:0] va, input bit allocate);
        int unsigned slot;
        int unsigned idx;
        int unsigned limit;
        int unsigned tab;
        slot = va[31:22];
        idx = va[21:12];
        limit = (pool_limit > TABLE_SLOTS) ? TABLE_SLOTS : pool_limit;
        if (dir_slot_tab[slot] == 0)
        begin
            if (!allocate || tables_taken >= limit)
                return -1;
            tab = tables_taken;
            tables_taken++;
            for (int k = 0; k < TABLE_ENTRIES; k++)
                page_entries[tab*TABLE_ENTRIES + k] = '0;
            dir_slot_tab[slot] = tab + 1;
        end
        else
        begin
            tab = dir_slot_tab[slot] - 1;
            if (tab >= TABLE_SLOTS)
                return -1;
        end
        return tab*TABLE_ENTRIES + idx;
    endfunction

    // Applies one command to the predicted tables and returns its result.
    function automatic walk_result_t walk_tables(input logic [1:0] op, input logic [31:0] va,
                                                 input logic [31:0] pa, input logic [11:0] fl);
        walk_result_t r;
        int pos;
        r = '0;
        if (op == tlptm_pkg::CMD_MAP)
        begin
            pos = find_entry(va, 1'b1);
            if (pos < 0)
                r.status = 1'b1;
            else
            begin
                if (!page_entries[pos][0])
                    present_pages++;
                page_entries[pos] = {pa[31:12], fl} | 32'd1;
            end
        end
        else if (op == tlptm_pkg::CMD_UNMAP)
        begin
            pos = find_entry(va, 1'b0);
            if (pos >= 0 && page_entries[pos][0])
            begin
                page_entries[pos] = '0;
                if (present_pages > 0)
                    present_pages--;
            end
        end
        else
        begin
            // Translate; the undefined code behaves the same way.
            pos = find_entry(va, 1'b0);
            if (pos >= 0 && page_entries[pos][0])
            begin
                r.is_present = 1'b1;
                r.translated_addr = {page_entries[pos][31:12], va[11:0]};
            end
        end
        r.mapped_count = present_pages[14:0];
        return r;
    endfunction

    // Offers one command until the block takes it, then records what it should return.
    task automatic send_command(input logic [1:0] op, input logic [31:0] va,
                                input logic [31:0] pa, input logic [11:0] fl,
                                input logic use_fixed, input walk_result_t fixed_want);
        int gap;
        walk_result_t predicted;
        steady_flow = ((item_no / 40) % 5) == 4;
        item_no++;
        gap = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        virt_addr <= va;
        phys_addr <= pa;
        entry_flags <= fl;
        do
            @(posedge clk);
        while (in_stall);
        predicted = walk_tables(op, va, pa, fl);
        expected_walks.push_back(use_fixed ? fixed_want : predicted);
    endtask

    // Stops offering commands until every outstanding result has been transferred.
    task automatic settle_pending();
        in_valid <= 1'b0;
        while (expected_walks.size() != 0)
            @(posedge clk);
    endtask

    // Writes the table pool limit register.
    task automatic set_pool_limit(input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_data <= value[4:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        pool_limit = value[4:0];
    endtask

    // Random command, mostly on a few hot slots and entries so tables fill and get reused.
    task automatic random_command(output logic [1:0] op, output logic [31:0] va,
                                  output logic [31:0] pa, output logic [11:0] fl);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            op = tlptm_pkg::CMD_MAP;
        else if (pick < 65)
            op = tlptm_pkg::CMD_UNMAP;
        else if (pick < 95)
            op = tlptm_pkg::CMD_XLATE;
        else
            op = CMD_UNDEFINED;
        if ($urandom_range(0, 9) == 0)
            va = $urandom();
        else
            va = {hot_slots[$urandom_range(0, 23)], hot_entries[$urandom_range(0, 7)],
                  12'($urandom())};
        pa = $urandom();
        fl = 12'($urandom_range(0, 4095));
    endtask

    // Result side: random stall per result, one long hold-off on request.
    initial
    begin
        int stall_cycles;
        wait (rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_cycles = HOLD_OFF_CYCLES;
            end
            else if (steady_flow)
                stall_cycles = 0;
            else
                stall_cycles = $urandom_range(0, MAX_GAP);
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge clk)
    begin
        walk_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_walks.size() == 0)
            begin
                error_count++;
                if (shown_count < MAX_SHOWN)
                    $display("unexpected result: status %0d present %0d addr %h count %0d",
                             status, is_present, translated_addr, mapped_count);
                shown_count++;
            end
            else
            begin
                want = expected_walks.pop_front();
                if (status !== want.status || is_present !== want.is_present ||
                    translated_addr !== want.translated_addr ||
                    mapped_count !== want.mapped_count)
                begin
                    error_count++;
                    if (shown_count < MAX_SHOWN)
                    begin
                        $write("mismatch (expected/actual):");
                        $display(" status %0d/%0d present %0d/%0d addr %h/%h count %0d/%0d",
                                 want.status, status, want.is_present, is_present,
                                 want.translated_addr, translated_addr,
                                 want.mapped_count, mapped_count);
                    end
                    shown_count++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then random phases at several pool limits.
    initial
    begin
        logic [1:0]  op;
        logic [31:0] va;
        logic [31:0] pa;
        logic [11:0] fl;
        int          guard;

        foreach (dir_slot_tab[i])
            dir_slot_tab[i] = 0;
        foreach (page_entries[i])
            page_entries[i] = '0;
        tables_taken = 0;
        present_pages = 0;
        pool_limit = tlptm_pkg::CFG_RESET;

        hot_slots[0] = 10'd0;
        hot_slots[1] = 10'd1023;
        for (int i = 2; i < 24; i++)
            hot_slots[i] = 10'($urandom_range(0, 1023));
        hot_entries[0] = 10'd0;
        hot_entries[1] = 10'd1023;
        for (int i = 2; i < 8; i++)
            hot_entries[i] = 10'($urandom_range(0, 1023));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands with a pool of two tables.
        set_pool_limit(2);
        foreach (directed_rows[i])
            send_command(directed_rows[i].op, directed_rows[i].va, directed_rows[i].pa,
                         directed_rows[i].flags, directed_rows[i].fixed,
                         directed_rows[i].want);

        for (int p = 0; p < PHASES; p++)
        begin
            settle_pending();
            set_pool_limit(phase_limit[p]);
            // Long receiver hold-off while commands keep coming.
            if (phase_limit[p] == TABLE_SLOTS)
                hold_off_req = 1'b1;
            for (int n = 0; n < phase_items[p]; n++)
            begin
                // Sender pauses mid-phase until the block has drained.
                if (p == 3 && n == phase_items[p] / 2)
                    settle_pending();
                random_command(op, va, pa, fl);
                send_command(op, va, pa, fl, 1'b0, '0);
            end
        end

        // Drain, then wait on for any stray result.
        in_valid <= 1'b0;
        guard = 0;
        while (expected_walks.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_walks.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

[files.f]
+incdir+rtl
rtl/tlptm_pkg.sv
rtl/two_level_page_table_manager.sv
tb/testbench.sv
